// ===== src/vnf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the fractal value noise pipeline.
package vnf_pkg;

  localparam int VNF_MAX_OCTAVES = 12;

  localparam int VNF_AMP_W  = 17;
  localparam int VNF_SUM_W  = 46;
  localparam int VNF_WSUM_W = 21;
  localparam int VNF_MAG_W  = 45;
  localparam int VNF_DIV_W  = 30;
  localparam int VNF_QBITS  = 15;

  localparam int VNF_SEED_STEP = 313;
  localparam int VNF_SALT_STEP = 3571;

  localparam logic [31:0] VNF_HASH_X   = 32'h9e3779b9;
  localparam logic [31:0] VNF_HASH_Y   = 32'h85ebca6b;
  localparam logic [31:0] VNF_HASH_S   = 32'hc2b2ae35;
  localparam logic [31:0] VNF_AV1      = 32'h7feb352d;
  localparam logic [31:0] VNF_AV2      = 32'h846ca68b;
  localparam logic [31:0] VNF_DIV100   = 32'h51eb851f;
  localparam logic [25:0] VNF_THREE24  = 26'd50331648;
  localparam logic signed [25:0] VNF_ONE24 = 26'sd16777216;
  localparam logic [16:0] VNF_AMP_ONE  = 17'h10000;

  localparam logic [31:0] VNF_RST_FREQ    = 32'd196608;
  localparam logic [3:0]  VNF_RST_OCTAVES = 4'd4;
  localparam logic [15:0] VNF_RST_ROUGH   = 16'd32768;
  localparam logic [31:0] VNF_RST_SEED    = 32'd1337;
  localparam logic [31:0] VNF_RST_SALT    = 32'd0;

  typedef enum logic [2:0] {
    CFG_BASE_FREQ  = 3'd0,
    CFG_OCTAVES    = 3'd1,
    CFG_ROUGHNESS  = 3'd2,
    CFG_SEED       = 3'd3,
    CFG_SALT       = 3'd4
  } vnf_cfg_idx_t;

  typedef struct packed {
    logic signed [31:0]           cx;
    logic signed [31:0]           cy;
    logic [31:0]                  freq;
    logic [VNF_AMP_W-1:0]         amp;
    logic signed [VNF_SUM_W-1:0]  sum;
    logic [VNF_WSUM_W-1:0]        wsum;
  } vnf_item_t;

  typedef struct packed {
    logic [31:0] seed;
    logic [31:0] salt;
    logic [15:0] rough;
    logic [4:0]  octaves;
  } vnf_cfg_t;

  typedef struct packed {
    logic [VNF_MAG_W-1:0] rem;
    logic [VNF_QBITS-1:0] q;
    logic [VNF_DIV_W-1:0] d;
    logic                 neg;
    logic                 zero;
    logic                 ovf;
  } vnf_div_t;

endpackage

// ===== src/vnf_octave.sv =====
`timescale 1ns / 1ps
// One noise octave: scale, lattice hash, smoothstep blend and weighted accumulate.
module vnf_octave import vnf_pkg::*; #(
  parameter int OCT_IDX = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  vnf_item_t in_item,
  input  vnf_cfg_t  cfg,
  output logic      out_valid,
  output vnf_item_t out_item
);

  localparam logic [31:0] SEED_OFS = 32'(OCT_IDX * VNF_SEED_STEP);
  localparam logic [31:0] SALT_OFS = 32'(OCT_IDX * VNF_SALT_STEP);
  localparam logic [4:0]  IDX      = 5'(OCT_IDX);

  logic [8:0]  v_r;
  vnf_item_t   it_r [0:8];

  // stage A
  logic signed [64:0] pxf, pyf;
  logic [63:0] frqf;
  logic [63:0] px_a_r, py_a_r, frq_a_r;
  logic [31:0] sd_a_r, st_a_r;

  // stage B
  logic [31:0] ix, iy, ix1, iy1;
  logic [23:0] fx, fy;
  logic [47:0] fxx, fyy;
  logic [33:0] fnext;
  vnf_item_t   it_b;
  logic [31:0] hx0_b_r, hx1_b_r, hy0_b_r, hy1_b_r, hsd_b_r, st_b_r;
  logic [23:0] fx2_b_r, fy2_b_r;
  logic [25:0] tx_b_r, ty_b_r;

  // stage C
  logic [31:0] hc [0:3];
  logic [31:0] m1_c_r [0:3];
  logic [49:0] sxx, syy;
  logic [24:0] sx_c_r, sy_c_r;

  // stage D
  logic [31:0] m2_d_r [0:3];
  logic [24:0] sx_d_r, sy_d_r;

  // stage E
  logic [23:0] ce [0:3];
  logic signed [24:0] dx0, dx1;
  logic signed [50:0] pe0, pe1;
  logic [23:0] c0_e_r, c2_e_r;
  logic signed [50:0] px0_e_r, px1_e_r;
  logic [24:0] sy_e_r;

  // stage F
  logic [26:0] af, bf;
  logic [23:0] a_f_r, b_f_r;
  logic [24:0] sy_f_r;

  // stage G
  logic signed [24:0] dy;
  logic signed [50:0] pg;
  logic [23:0] a_g_r;
  logic signed [50:0] py_g_r;

  // stage H
  logic [26:0] lh;
  logic signed [25:0] nh;
  logic signed [43:0] namp;
  logic signed [43:0] namp_h_r;

  // stage I
  logic [32:0] ampm;
  logic        active;
  vnf_item_t   it_i;

  assign active = IDX < cfg.octaves;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[7:0], in_valid};
    end
  end

  always_comb begin
    pxf  = in_item.cx * $signed({1'b0, in_item.freq});
    pyf  = in_item.cy * $signed({1'b0, in_item.freq});
    frqf = {32'b0, in_item.freq} * {32'b0, VNF_DIV100};
  end

  always_comb begin
    ix   = px_a_r[63:32];
    iy   = py_a_r[63:32];
    ix1  = ix + 32'd1;
    iy1  = iy + 32'd1;
    fx   = px_a_r[31:8];
    fy   = py_a_r[31:8];
    fxx  = {24'b0, fx} * {24'b0, fx};
    fyy  = {24'b0, fy} * {24'b0, fy};
    fnext = {1'b0, it_r[0].freq, 1'b0} + {7'b0, frq_a_r[63:37]};
    it_b = it_r[0];
    it_b.freq = (fnext[33:32] != 2'b00) ? 32'hffffffff : fnext[31:0];
  end

  always_comb begin
    hc[0] = hx0_b_r ^ hy0_b_r ^ hsd_b_r ^ st_b_r;
    hc[1] = hx1_b_r ^ hy0_b_r ^ hsd_b_r ^ st_b_r;
    hc[2] = hx0_b_r ^ hy1_b_r ^ hsd_b_r ^ st_b_r;
    hc[3] = hx1_b_r ^ hy1_b_r ^ hsd_b_r ^ st_b_r;
    sxx = {26'b0, fx2_b_r} * {24'b0, tx_b_r};
    syy = {26'b0, fy2_b_r} * {24'b0, ty_b_r};
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ce[k] = m2_d_r[k][23:0] ^ m2_d_r[k][31:16] ^ 24'(0);
    end
    dx0 = $signed({1'b0, ce[1]}) - $signed({1'b0, ce[0]});
    dx1 = $signed({1'b0, ce[3]}) - $signed({1'b0, ce[2]});
    pe0 = dx0 * $signed({1'b0, sx_d_r});
    pe1 = dx1 * $signed({1'b0, sx_d_r});
  end

  always_comb begin
    af = {3'b0, c0_e_r} + px0_e_r[50:24];
    bf = {3'b0, c2_e_r} + px1_e_r[50:24];
    dy = $signed({1'b0, b_f_r}) - $signed({1'b0, a_f_r});
    pg = dy * $signed({1'b0, sy_f_r});
    lh = {3'b0, a_g_r} + py_g_r[50:24];
    nh = $signed({1'b0, lh[23:0], 1'b0}) - VNF_ONE24;
    namp = nh * $signed({1'b0, it_r[6].amp});
  end

  always_comb begin
    ampm = it_r[7].amp * cfg.rough;
    it_i = it_r[7];
    if (active) begin
      it_i.sum  = it_r[7].sum + {{(VNF_SUM_W-44){namp_h_r[43]}}, namp_h_r};
      it_i.wsum = it_r[7].wsum + {{(VNF_WSUM_W-VNF_AMP_W){1'b0}}, it_r[7].amp};
      it_i.amp  = ampm[32:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_r[0] <= in_item;
      px_a_r  <= pxf[63:0];
      py_a_r  <= pyf[63:0];
      frq_a_r <= frqf;
      sd_a_r  <= cfg.seed + SEED_OFS;
      st_a_r  <= cfg.salt + SALT_OFS;

      it_r[1] <= it_b;
      hx0_b_r <= ix * VNF_HASH_X;
      hx1_b_r <= ix1 * VNF_HASH_X;
      hy0_b_r <= iy * VNF_HASH_Y;
      hy1_b_r <= iy1 * VNF_HASH_Y;
      hsd_b_r <= sd_a_r * VNF_HASH_S;
      st_b_r  <= st_a_r;
      fx2_b_r <= fxx[47:24];
      fy2_b_r <= fyy[47:24];
      tx_b_r  <= VNF_THREE24 - {1'b0, fx, 1'b0};
      ty_b_r  <= VNF_THREE24 - {1'b0, fy, 1'b0};

      for (int k = 0; k < 4; k++) begin
        m1_c_r[k] <= (hc[k] ^ (hc[k] >> 16)) * VNF_AV1;
        m2_d_r[k] <= (m1_c_r[k] ^ (m1_c_r[k] >> 15)) * VNF_AV2;
      end
      sx_c_r <= sxx[48:24];
      sy_c_r <= syy[48:24];
      sx_d_r <= sx_c_r;
      sy_d_r <= sy_c_r;

      c0_e_r  <= ce[0];
      c2_e_r  <= ce[2];
      px0_e_r <= pe0;
      px1_e_r <= pe1;
      sy_e_r  <= sy_d_r;

      a_f_r  <= af[23:0];
      b_f_r  <= bf[23:0];
      sy_f_r <= sy_e_r;

      a_g_r  <= a_f_r;
      py_g_r <= pg;

      namp_h_r <= namp;

      for (int k = 2; k < 8; k++) begin
        it_r[k] <= it_r[k-1];
      end
      it_r[8] <= it_i;
    end
  end

  assign out_valid = v_r[8];
  assign out_item  = it_r[8];

endmodule

// ===== src/value_noise_fbm.sv =====
`timescale 1ns / 1ps
// Top level: configuration, octave pipeline chain, divider and output skid.
// Throughput: one coordinate per cycle while in_stall is low; each octave is a
// 9-stage pipeline, the normalizing divide is 16 stages: setup, then one restoring
// stage per quotient bit for 15 bits.
// Reset: synchronous active-low rst_n clears the pipeline, output and skid valid bits, and loads
// register defaults (frequency 3.0, 4 octaves, roughness 0.5, seed 1337, salt 0).
module value_noise_fbm import vnf_pkg::*; #(
  parameter int MAX_OCTAVES = VNF_MAX_OCTAVES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_noise_value,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  logic [31:0] base_frequency_r;
  logic [3:0]  octave_count_r;
  logic [15:0] roughness_r;
  logic [31:0] noise_seed_r;
  logic [31:0] hash_salt_r;

  vnf_cfg_t  cfg;
  logic      en;
  vnf_item_t first_item;
  vnf_item_t oct_it [0:MAX_OCTAVES];
  logic      oct_v  [0:MAX_OCTAVES];

  vnf_div_t  div_prep;
  vnf_div_t  dq_r   [0:VNF_QBITS];
  vnf_div_t  dq_nxt [1:VNF_QBITS];
  logic [VNF_QBITS:0] dv_r;
  logic [VNF_SUM_W-1:0] mag_full;

  logic signed [15:0] res;
  logic               arrive, take;
  logic               out_v_r, skid_v_r;
  logic signed [15:0] out_r, skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_frequency_r <= VNF_RST_FREQ;
      octave_count_r   <= VNF_RST_OCTAVES;
      roughness_r      <= VNF_RST_ROUGH;
      noise_seed_r     <= VNF_RST_SEED;
      hash_salt_r      <= VNF_RST_SALT;
    end else if (cfg_we) begin
      case (vnf_cfg_idx_t'(cfg_index))
        CFG_BASE_FREQ: base_frequency_r <= cfg_wdata;
        CFG_OCTAVES:   octave_count_r   <= cfg_wdata[3:0];
        CFG_ROUGHNESS: roughness_r      <= cfg_wdata[15:0];
        CFG_SEED:      noise_seed_r     <= cfg_wdata;
        CFG_SALT:      hash_salt_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.seed  = noise_seed_r;
    cfg.salt  = hash_salt_r;
    cfg.rough = roughness_r;
    cfg.octaves = ({1'b0, octave_count_r} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES)
                                                              : {1'b0, octave_count_r};
  end

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  always_comb begin
    first_item.cx   = in_coord_x;
    first_item.cy   = in_coord_y;
    first_item.freq = base_frequency_r;
    first_item.amp  = VNF_AMP_ONE;
    first_item.sum  = '0;
    first_item.wsum = '0;
  end

  assign oct_it[0] = first_item;
  assign oct_v[0]  = in_valid;

  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_oct
    vnf_octave #(
      .OCT_IDX(g)
    ) u_oct (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (oct_v[g]),
      .in_item  (oct_it[g]),
      .cfg      (cfg),
      .out_valid(oct_v[g+1]),
      .out_item (oct_it[g+1])
    );
  end

  always_comb begin
    mag_full      = oct_it[MAX_OCTAVES].sum[VNF_SUM_W-1] ? -oct_it[MAX_OCTAVES].sum
                                                         : oct_it[MAX_OCTAVES].sum;
    div_prep.rem  = mag_full[VNF_MAG_W-1:0];
    div_prep.q    = '0;
    div_prep.d    = {oct_it[MAX_OCTAVES].wsum, 9'b0};
    div_prep.neg  = oct_it[MAX_OCTAVES].sum[VNF_SUM_W-1];
    div_prep.zero = (oct_it[MAX_OCTAVES].wsum == '0);
    div_prep.ovf  = div_prep.rem >= {div_prep.d, {VNF_QBITS{1'b0}}};
  end

  for (genvar j = 1; j <= VNF_QBITS; j++) begin : g_div
    localparam int B = VNF_QBITS - j;
    logic [VNF_MAG_W-1:0] trial;
    always_comb begin
      trial     = VNF_MAG_W'(dq_r[j-1].d) << B;
      dq_nxt[j] = dq_r[j-1];
      if (dq_r[j-1].rem >= trial) begin
        dq_nxt[j].rem  = dq_r[j-1].rem - trial;
        dq_nxt[j].q[B] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (en) begin
      dv_r <= {dv_r[VNF_QBITS-1:0], oct_v[MAX_OCTAVES]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dq_r[0] <= div_prep;
      for (int j = 1; j <= VNF_QBITS; j++) begin
        dq_r[j] <= dq_nxt[j];
      end
    end
  end

  always_comb begin
    if (dq_r[VNF_QBITS].zero) begin
      res = 16'sd0;
    end else if (dq_r[VNF_QBITS].ovf) begin
      res = dq_r[VNF_QBITS].neg ? 16'sh8000 : 16'sh7fff;
    end else if (dq_r[VNF_QBITS].neg) begin
      res = -$signed({1'b0, dq_r[VNF_QBITS].q});
    end else begin
      res = $signed({1'b0, dq_r[VNF_QBITS].q});
    end
  end

  assign take   = out_v_r && !out_stall;
  assign arrive = en && dv_r[VNF_QBITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        out_r    <= skid_r;
        skid_v_r <= 1'b0;
      end
    end else if (arrive) begin
      if (!out_v_r || take) begin
        out_r   <= res;
        out_v_r <= 1'b1;
      end else begin
        skid_r   <= res;
        skid_v_r <= 1'b1;
      end
    end else if (take) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_valid       = out_v_r;
  assign out_noise_value = out_r;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the fractal value noise pipeline.
module testbench;
  import vnf_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_coord_x;
  logic signed [31:0] in_coord_y;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_noise_value;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_wdata;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
  } coord_t;

  coord_t      coord_q[$];
  logic [15:0] noise_q[$];

  logic [31:0] m_freq;
  logic [3:0]  m_octaves;
  logic [15:0] m_rough;
  logic [31:0] m_seed;
  logic [31:0] m_salt;

  int  errors;
  int  transfers_in;
  int  transfers_out;
  bit  quiet;
  bit  drive_idle;
  int  in_gap;
  int  out_gap;

  value_noise_fbm uut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] mix32(logic [31:0] h);
    logic [63:0] p;
    h = h ^ (h >> 16);
    p = h * VNF_AV1;
    h = p[31:0];
    h = h ^ (h >> 15);
    p = h * VNF_AV2;
    h = p[31:0];
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic longint lattice_hash(logic [31:0] ix, logic [31:0] iy,
                                          logic [31:0] sd, logic [31:0] st);
    logic [31:0] h;
    h = ix * VNF_HASH_X;
    h = h ^ (iy * VNF_HASH_Y);
    h = h ^ (sd * VNF_HASH_S);
    h = h ^ st;
    h = mix32(h);
    return longint'({8'd0, h[23:0]});
  endfunction

  function automatic longint fade(logic [23:0] f);
    longint unsigned f2;
    longint unsigned t;
    f2 = (longint'(f) * longint'(f)) >> 24;
    t = 64'd50331648 - 2 * longint'(f);
    return longint'((f2 * t) >> 24);
  endfunction

  function automatic longint mixw(longint a, longint b, longint s);
    return a + ((b - a) * s >>> 24);
  endfunction

  function automatic longint octave_value(logic [63:0] px, logic [63:0] py,
                                          logic [31:0] sd, logic [31:0] st);
    logic [31:0] ix, iy;
    longint sx, sy, a, b, l;
    ix = px[63:32];
    iy = py[63:32];
    sx = fade(px[31:8]);
    sy = fade(py[31:8]);
    a = mixw(lattice_hash(ix, iy, sd, st), lattice_hash(ix + 1, iy, sd, st), sx);
    b = mixw(lattice_hash(ix, iy + 1, sd, st), lattice_hash(ix + 1, iy + 1, sd, st), sx);
    l = mixw(a, b, sy);
    return 2 * l - 64'sd16777216;
  endfunction

  function automatic logic [15:0] fbm_noise(logic [31:0] x, logic [31:0] y);
    longint cx, cy, sum, res, n;
    longint unsigned freq, amp, weight;
    int count;
    cx = longint'(signed'(x));
    cy = longint'(signed'(y));
    count = (m_octaves > VNF_MAX_OCTAVES) ? VNF_MAX_OCTAVES : m_octaves;
    freq = m_freq;
    amp = 65536;
    weight = 0;
    sum = 0;
    res = 0;
    for (int i = 0; i < count; i++) begin
      n = octave_value(cx * longint'(freq), cy * longint'(freq),
                       m_seed + i * VNF_SEED_STEP, m_salt + i * VNF_SALT_STEP);
      sum += n * longint'(amp);
      weight += amp;
      freq = freq * 201 / 100;
      if (freq > 64'hffffffff) freq = 64'hffffffff;
      amp = (amp * m_rough) >> 16;
    end
    if (weight != 0) begin
      res = sum / longint'(weight << 9);
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
    end
    return res[15:0];
  endfunction

  task automatic report(string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  task automatic write_reg(vnf_cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BASE_FREQ: m_freq = val;
      CFG_OCTAVES:   m_octaves = val[3:0];
      CFG_ROUGHNESS: m_rough = val[15:0];
      CFG_SEED:      m_seed = val;
      default:       m_salt = val;
    endcase
  endtask

  task automatic drain();
    wait (coord_q.size() == 0 && noise_q.size() == 0);
    repeat (9 * VNF_MAX_OCTAVES + 30) @(posedge clk);
  endtask

  task automatic push_coord(logic [31:0] x, logic [31:0] y);
    coord_t c;
    c.x = x;
    c.y = y;
    coord_q.push_back(c);
  endtask

  task automatic random_batch(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: push_coord($urandom, $urandom);
        1: push_coord($urandom_range(0, 2000000) - 1000000,
                      $urandom_range(0, 2000000) - 1000000);
        2: push_coord({{16{1'b0}}, 16'($urandom)}, {{16{1'b1}}, 16'($urandom)});
        default: push_coord(32'h80000000 | $urandom_range(0, 255), 32'h7fffff00 | $urandom_range(0, 255));
      endcase
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        noise_q.push_back(fbm_noise(in_coord_x, in_coord_y));
        void'(coord_q.pop_front());
        transfers_in++;
      end
      if (in_valid && in_stall) begin
        // hold
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        in_gap <= $urandom_range(0, 13);
        in_valid <= 1'b0;
      end else if (!drive_idle && coord_q.size() > (in_valid && !in_stall ? 0 : 0)) begin
        in_valid <= 1'b1;
        in_coord_x <= coord_q[0].x;
        in_coord_y <= coord_q[0].y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        transfers_out++;
        if (noise_q.size() == 0) begin
          report($sformatf("unexpected noise_value %0d", out_noise_value));
        end else begin
          if (out_noise_value !== noise_q[0])
            report($sformatf("noise_value got %0d want %0d", out_noise_value,
                             signed'(noise_q[0])));
          void'(noise_q.pop_front());
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        out_gap <= $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    errors = 0;
    transfers_in = 0;
    transfers_out = 0;
    quiet = 1'b0;
    drive_idle = 1'b1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_coord_x = '0;
    in_coord_y = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_BASE_FREQ;
    cfg_wdata = '0;
    m_freq = VNF_RST_FREQ;
    m_octaves = VNF_RST_OCTAVES;
    m_rough = VNF_RST_ROUGH;
    m_seed = VNF_RST_SEED;
    m_salt = VNF_RST_SALT;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed at reset settings
    push_coord(32'h0, 32'h0);
    push_coord(32'h7fffffff, 32'h7fffffff);
    push_coord(32'h80000000, 32'h80000000);
    push_coord(32'h7fffffff, 32'h80000000);
    push_coord(32'hffffffff, 32'h00000001);
    push_coord(32'h00008000, 32'hffff8000);
    push_coord(32'h0000ffff, 32'h00010000);
    push_coord(32'h55555555, 32'haaaaaaaa);
    push_coord(32'haaaaaaaa, 32'h55555555);
    drive_idle = 1'b0;
    drain();

    // zero octaves gives a zero result
    drive_idle = 1'b1;
    write_reg(CFG_OCTAVES, 32'd0);
    push_coord(32'h12345678, 32'h9abcdef0);
    push_coord(32'h80000000, 32'h7fffffff);
    drive_idle = 1'b0;
    drain();

    // more than MAX_OCTAVES, saturating frequency, near-unity roughness
    drive_idle = 1'b1;
    write_reg(CFG_OCTAVES, 32'd15);
    write_reg(CFG_BASE_FREQ, 32'hffffffff);
    write_reg(CFG_ROUGHNESS, 32'hffff);
    write_reg(CFG_SEED, 32'h80000000);
    write_reg(CFG_SALT, 32'hffffffff);
    push_coord(32'h7fffffff, 32'h80000000);
    push_coord(32'h00000001, 32'hffffffff);
    push_coord(32'h00010000, 32'h00010000);
    drive_idle = 1'b0;
    drain();
    drive_idle = 1'b1;
    write_reg(CFG_ROUGHNESS, 32'd0);
    write_reg(CFG_OCTAVES, 32'd1);
    write_reg(CFG_BASE_FREQ, 32'h00010000);
    // a single octave sampled on lattice points and just before the next one
    push_coord(32'h00000000, 32'h00000000);
    push_coord(32'h0000ffff, 32'h0000ffff);
    push_coord(32'h00010000, 32'hffff0000);
    drive_idle = 1'b0;
    drain();

    // random phases across settings
    for (int ph = 0; ph < 6; ph++) begin
      drive_idle = 1'b1;
      write_reg(CFG_BASE_FREQ, ph == 0 ? 32'd0 : (ph == 1 ? 32'hffffffff : $urandom_range(0, 32'h80000)));
      write_reg(CFG_OCTAVES, ph == 2 ? 32'd12 : $urandom_range(1, 12));
      write_reg(CFG_ROUGHNESS, ph == 3 ? 32'd3277 : (ph == 4 ? 32'd62259 : $urandom_range(3277, 62259)));
      write_reg(CFG_SEED, $urandom);
      write_reg(CFG_SALT, $urandom);
      if (ph == 5) quiet = 1'b1;
      random_batch(65);
      drive_idle = 1'b0;
      drain();
    end

    $display("covered %0d coordinate transfers in and %0d noise transfers out", transfers_in,
             transfers_out);
    $display("settings swept: frequency, octave count, roughness, seed and salt extremes");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
